>>> design/cdq_pkg.sv
// cdq_pkg: shared types and constants of the circular deque
// action codes, result flag bundle, default sizes and the capacity reset value
// no dependencies
`default_nettype none

package cdq_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int CAP_W           = 5;
  localparam int ACT_W           = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_REAR  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_REAR   = 3'd3,
    ACT_PEEK       = 3'd4
  } action_e;

  typedef struct packed {
    logic valid;
    logic accepted;
    logic empty;
    logic full;
  } res_flags_t;

endpackage

`default_nettype wire

>>> design/circular_deque.sv
// circular_deque: ring-buffer double-ended queue, top level
// instantiates cdq_ctrl and cdq_store; depends on cdq_pkg
//
// channel   | handshake                 | payload
// ----------+---------------------------+-----------------------------------------
// command   | start_i, busy_o           | action_i, entry_value_i
// result    | done_o (one-cycle strobe) | accepted_o, front_value_o, rear_value_o,
//           |                           | is_empty_o, is_full_o
// config    | cfg_valid_i, cfg_ready_o  | cfg_data_i (capacity in use)
//
// one transaction per cycle unless busy_o holds it; a taken command passes the input register,
// then the state and result registers, which drive done_o and the result
// busy_o is high only in a cycle in which a config write is taken
// cfg_ready_o is low while a transaction is still in the two stages
// reset clears pointers and flags and sets capacity to 16; storage is not cleared
// the result side cannot stall: each result is shown for exactly one cycle
`default_nettype none

module circular_deque #(
  parameter int DEPTH       = cdq_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = cdq_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic [cdq_pkg::ACT_W-1:0]   action_i,
  input  wire logic [VALUE_WIDTH-1:0]      entry_value_i,
  output logic                             done_o,
  output logic                             accepted_o,
  output logic      [VALUE_WIDTH-1:0]      front_value_o,
  output logic      [VALUE_WIDTH-1:0]      rear_value_o,
  output logic                             is_empty_o,
  output logic                             is_full_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [cdq_pkg::CAP_W-1:0]   cfg_data_i
);

  localparam int IDX_W = $clog2(DEPTH);

  logic                    take;
  logic                    cfg_we;
  logic                    we;
  logic [IDX_W-1:0]        waddr;
  logic [VALUE_WIDTH-1:0]  wdata;
  logic                    re;
  logic [IDX_W-1:0]        raddr_front;
  logic [IDX_W-1:0]        raddr_rear;
  logic [VALUE_WIDTH-1:0]  rdata_front;
  logic [VALUE_WIDTH-1:0]  rdata_rear;
  cdq_pkg::res_flags_t     res;

  assign cfg_we = cfg_valid_i && cfg_ready_o;
  assign busy_o = cfg_we;
  assign take   = start_i && !busy_o;

  cdq_ctrl #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .action_i      (action_i),
    .entry_value_i (entry_value_i),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data_i),
    .cfg_ready_o   (cfg_ready_o),
    .we_o          (we),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .re_o          (re),
    .raddr_front_o (raddr_front),
    .raddr_rear_o  (raddr_rear),
    .res_o         (res)
  );

  cdq_store #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_store (
    .clk_i         (clk_i),
    .we_i          (we),
    .waddr_i       (waddr),
    .wdata_i       (wdata),
    .re_i          (re),
    .raddr_front_i (raddr_front),
    .raddr_rear_i  (raddr_rear),
    .rdata_front_o (rdata_front),
    .rdata_rear_o  (rdata_rear)
  );

  // empty deque reads as all ones
  assign done_o        = res.valid;
  assign accepted_o    = res.accepted;
  assign is_empty_o    = res.empty;
  assign is_full_o     = res.full;
  assign front_value_o = res.empty ? '1 : rdata_front;
  assign rear_value_o  = res.empty ? '1 : rdata_rear;

endmodule

`default_nettype wire

>>> design/cdq_store.sv
// cdq_store: entry storage of the circular deque
// one write port, two registered read ports with write-first bypass
// depends on nothing but its parameters
`default_nettype none

module cdq_store #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire logic [VALUE_WIDTH-1:0]     wdata_i,
  input  wire logic                       re_i,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_front_i,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_rear_i,
  output logic      [VALUE_WIDTH-1:0]     rdata_front_o,
  output logic      [VALUE_WIDTH-1:0]     rdata_rear_o
);

  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rdata_front_q;
  logic [VALUE_WIDTH-1:0] rdata_rear_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_front_i)) begin
        rdata_front_q <= wdata_i;
      end else begin
        rdata_front_q <= mem[raddr_front_i];
      end
      if (we_i && (waddr_i == raddr_rear_i)) begin
        rdata_rear_q <= wdata_i;
      end else begin
        rdata_rear_q <= mem[raddr_rear_i];
      end
    end
  end

  assign rdata_front_o = rdata_front_q;
  assign rdata_rear_o  = rdata_rear_q;

endmodule

`default_nettype wire

>>> design/cdq_ctrl.sv
// cdq_ctrl: input register, pointer and flag update, result flag register
// drives the storage ports of cdq_store; holds the capacity register
// depends on cdq_pkg
`default_nettype none

module cdq_ctrl #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         take_i,
  input  wire logic [cdq_pkg::ACT_W-1:0]    action_i,
  input  wire logic [VALUE_WIDTH-1:0]       entry_value_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [cdq_pkg::CAP_W-1:0]    cfg_data_i,
  output logic                              cfg_ready_o,
  output logic                              we_o,
  output logic      [$clog2(DEPTH)-1:0]     waddr_o,
  output logic      [VALUE_WIDTH-1:0]       wdata_o,
  output logic                              re_o,
  output logic      [$clog2(DEPTH)-1:0]     raddr_front_o,
  output logic      [$clog2(DEPTH)-1:0]     raddr_rear_o,
  output cdq_pkg::res_flags_t               res_o
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CCW   = (IDX_W + 1 > cdq_pkg::CAP_W) ? IDX_W + 1 : cdq_pkg::CAP_W;

  function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i,
                                               input logic [CCW-1:0]   c);
    logic [CCW-1:0] n;
    n = CCW'(i) + CCW'(1);
    return (n >= c) ? '0 : n[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i,
                                                 input logic [CCW-1:0]   c);
    logic [CCW-1:0] m;
    m = c - CCW'(1);
    return (i == '0) ? m[IDX_W-1:0] : i - IDX_W'(1);
  endfunction

  logic                        item_vld_q;
  cdq_pkg::action_e            item_act_q;
  logic [VALUE_WIDTH-1:0]      item_val_q;
  logic [cdq_pkg::CAP_W-1:0]   cap_q;
  logic [IDX_W-1:0]            head_q, head_d;
  logic [IDX_W-1:0]            tail_q, tail_d;
  logic                        empty_q, empty_d;
  cdq_pkg::res_flags_t         res_q, res_d;
  logic [CCW-1:0]              cap_ext;
  logic [CCW-1:0]              eff_cap;
  logic                        full_now;
  logic                        ok;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else begin
      item_vld_q <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      item_act_q <= cdq_pkg::action_e'(action_i);
      item_val_q <= entry_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= cdq_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = !item_vld_q && !res_q.valid;

  // effective capacity, clamped to 1..DEPTH
  assign cap_ext = CCW'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CCW'(1);
    end else if (cap_ext > CCW'(DEPTH)) begin
      eff_cap = CCW'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full_now = !empty_q && (head_q == step_up(tail_q, eff_cap));

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    empty_d = empty_q;
    we_o    = 1'b0;
    waddr_o = '0;
    ok      = 1'b0;
    unique case (item_act_q)
      cdq_pkg::ACT_PUSH_FRONT: begin
        if (empty_q) begin
          head_d  = '0;
          tail_d  = '0;
          empty_d = 1'b0;
          we_o    = 1'b1;
          ok      = 1'b1;
        end else if (!full_now) begin
          head_d  = step_down(head_q, eff_cap);
          waddr_o = head_d;
          we_o    = 1'b1;
          ok      = 1'b1;
        end
      end
      cdq_pkg::ACT_PUSH_REAR: begin
        if (empty_q) begin
          head_d  = '0;
          tail_d  = '0;
          empty_d = 1'b0;
          we_o    = 1'b1;
          ok      = 1'b1;
        end else if (!full_now) begin
          tail_d  = step_up(tail_q, eff_cap);
          waddr_o = tail_d;
          we_o    = 1'b1;
          ok      = 1'b1;
        end
      end
      cdq_pkg::ACT_POP_FRONT: begin
        if (!empty_q) begin
          if (head_q == tail_q) begin
            empty_d = 1'b1;
          end else begin
            head_d = step_up(head_q, eff_cap);
          end
          ok = 1'b1;
        end
      end
      cdq_pkg::ACT_POP_REAR: begin
        if (!empty_q) begin
          if (head_q == tail_q) begin
            empty_d = 1'b1;
          end else begin
            tail_d = step_down(tail_q, eff_cap);
          end
          ok = 1'b1;
        end
      end
      cdq_pkg::ACT_PEEK: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    if (!item_vld_q) begin
      we_o = 1'b0;
    end
  end

  assign wdata_o       = item_val_q;
  assign re_o          = item_vld_q;
  assign raddr_front_o = head_d;
  assign raddr_rear_o  = tail_d;

  always_comb begin
    res_d          = res_q;
    res_d.valid    = item_vld_q;
    if (item_vld_q) begin
      res_d.accepted = ok;
      res_d.empty    = empty_d;
      res_d.full     = !empty_d && (head_d == step_up(tail_d, eff_cap));
    end
  end

  // deque state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
    end else if (item_vld_q) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
    end
  end

  // result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

`ifndef SYNTHESIS
  a_res_follows_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_vld_q |=> res_q.valid)
    else $error("result strobe missing after item");

  a_no_spurious_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_vld_q |=> !res_q.valid)
    else $error("result strobe without item");

  a_refused_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_vld_q && !ok) |=> ($stable(head_q) && $stable(tail_q) && $stable(empty_q)))
    else $error("refused transaction changed deque state");

  a_last_pop_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_vld_q && !empty_q && (head_q == tail_q) &&
     ((item_act_q == cdq_pkg::ACT_POP_FRONT) || (item_act_q == cdq_pkg::ACT_POP_REAR)))
    |=> (empty_q && res_q.empty && !res_q.full))
    else $error("pop of last entry did not empty the deque");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.full |-> !res_q.empty)
    else $error("full and empty reported together");
`endif

endmodule

`default_nettype wire
